/* rtl/core/sktab_pkg.sv */
// Shared types and constants for the sorted key/value table.
`timescale 1ns / 1ps

package sktab_pkg;

    // Default sizes
    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int KEY_W      = 32;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int OUT_VAL_W  = 32;
    localparam int IN_VAL_W   = 32;
    localparam int OUT_POS_W  = 6;
    localparam int OUT_CNT_W  = 7;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    // Broadcast control to every cell of the chain
    typedef struct packed {
        logic cmp;  // compare stored key against request key
        logic ins;  // open a slot and write the new entry
        logic del;  // close the gap at the matching entry
        logic ovr;  // overwrite value of the matching entry
    } t_cell_ctl;

endpackage

/* rtl/core/sorted_key_value_table_core.sv */
// Top level of the sorted key/value table: request control, cell chain and result register.
`timescale 1ns / 1ps

// Usage
//   Request channel: drive i_kind, i_key, i_value and raise start; the item is
//   taken at a rising edge where start is high and busy is low.
//   Result channel: o_valid is high for exactly one cycle with o_status, o_hit,
//   o_old_value, o_position and o_entries; the receiver cannot stall it and
//   must take the item in that cycle.
//   Sequence: the compare state compares every stored key against the request
//   key in parallel (one comparator per cell); the update state then applies
//   the shift, insert, overwrite or delete across the chain and registers the
//   result. busy is high only in the compare state, so the next item may be
//   taken while the previous update is applied.
//   Reset (i_rst_n low, synchronous) empties the table by clearing the entry
//   count; key and value slots are not cleared and are never read before they
//   are written. No clearing pass is needed.
//   Kind code three is treated as a lookup.

module sorted_key_value_table_core #(
    parameter int CAPACITY    = sktab_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = sktab_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sktab_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [sktab_pkg::KEY_W-1:0]  i_key,
    input  logic [sktab_pkg::IN_VAL_W-1:0]      i_value,
    output logic                                o_valid,
    output logic [sktab_pkg::STATUS_W-1:0]      o_status,
    output logic                                o_hit,
    output logic [sktab_pkg::OUT_VAL_W-1:0]     o_old_value,
    output logic [sktab_pkg::OUT_POS_W-1:0]     o_position,
    output logic [sktab_pkg::OUT_CNT_W-1:0]     o_entries
);
    import sktab_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    t_state                  r_state;
    logic [CW-1:0]           r_count;
    logic [KIND_W-1:0]       r_kind;
    logic signed [KEY_W-1:0] r_req_key;
    logic [VALUE_WIDTH-1:0]  r_req_value;

    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_out_status;
    logic                    r_out_hit;
    logic [OUT_VAL_W-1:0]    r_out_old;
    logic [OUT_POS_W-1:0]    r_out_pos;
    logic [OUT_CNT_W-1:0]    r_out_cnt;

    logic                    accept;
    t_cell_ctl               cell_ctl;

    logic signed [KEY_W-1:0] cell_key   [CAPACITY];
    logic [VALUE_WIDTH-1:0]  cell_value [CAPACITY];
    logic [CAPACITY-1:0]     cell_lt;
    logic [CAPACITY-1:0]     cell_eq;

    logic                    hit;
    logic [VALUE_WIDTH-1:0]  hit_value;
    logic [IW-1:0]           hit_pos;
    logic                    full;
    logic [CW-1:0]           n_count;
    logic [STATUS_W-1:0]     n_status;

    logic [IN_VAL_W+VALUE_WIDTH-1:0]  in_value_ext;
    logic [VALUE_WIDTH+OUT_VAL_W-1:0] old_value_ext;
    logic [IW+OUT_POS_W-1:0]          pos_ext;
    logic [CW+OUT_CNT_W-1:0]          cnt_ext;

    assign busy   = (r_state == ST_CMP);
    assign accept = start && !busy;

    assign in_value_ext = {{VALUE_WIDTH{1'b0}}, i_value};

    // Match reduction over the chain: at most one cell matches
    always_comb begin
        hit_value = '0;
        hit_pos   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (cell_eq[i]) begin
                hit_value = hit_value | cell_value[i];
                hit_pos   = hit_pos | IW'(i);
            end
        end
    end
    assign hit  = |cell_eq;
    assign full = (r_count >= CW'(CAPACITY));

    // Table operation decode: compare strobe in the compare state, update control in the update cycle
    always_comb begin
        cell_ctl     = '0;
        cell_ctl.cmp = (r_state == ST_CMP);
        n_count      = r_count;
        n_status     = STATUS_DONE;
        case (r_kind)
            KIND_INSERT: begin
                if (hit) begin
                    cell_ctl.ovr = (r_state == ST_UPD);
                end else if (full) begin
                    n_status = STATUS_FULL;
                end else begin
                    cell_ctl.ins = (r_state == ST_UPD);
                    n_count      = r_count + CW'(1);
                end
            end
            KIND_DELETE: begin
                if (hit) begin
                    cell_ctl.del = (r_state == ST_UPD);
                    n_count      = r_count - CW'(1);
                end else begin
                    n_status = STATUS_MISS;
                end
            end
            default: begin
                if (!hit) begin
                    n_status = STATUS_MISS;
                end
            end
        endcase
    end

    // Cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [KEY_W-1:0] left_key;
        logic [VALUE_WIDTH-1:0]  left_value;
        logic                    left_lt;
        logic signed [KEY_W-1:0] right_key;
        logic [VALUE_WIDTH-1:0]  right_value;

        if (g == 0) begin : g_first
            assign left_key   = r_req_key;
            assign left_value = r_req_value;
            assign left_lt    = 1'b1;
        end else begin : g_mid_l
            assign left_key   = cell_key[g-1];
            assign left_value = cell_value[g-1];
            assign left_lt    = cell_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_key   = cell_key[g];
            assign right_value = cell_value[g];
        end else begin : g_mid_r
            assign right_key   = cell_key[g+1];
            assign right_value = cell_value[g+1];
        end

        sktab_cell #(
            .VALUE_WIDTH(VALUE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_occupied    (r_count > CW'(g)),
            .i_req_key     (r_req_key),
            .i_req_value   (r_req_value),
            .i_left_key    (left_key),
            .i_left_value  (left_value),
            .i_left_lt     (left_lt),
            .i_right_key   (right_key),
            .i_right_value (right_value),
            .o_key         (cell_key[g]),
            .o_value       (cell_value[g]),
            .o_lt          (cell_lt[g]),
            .o_eq          (cell_eq[g])
        );
    end

    // Result formatting to the fixed output widths
    assign old_value_ext = {{OUT_VAL_W{1'b0}}, hit_value};
    assign pos_ext       = {{OUT_POS_W{1'b0}}, hit_pos};
    assign cnt_ext       = {{OUT_CNT_W{1'b0}}, n_count};

    // Request capture (payload)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind      <= i_kind;
            r_req_key   <= i_key;
            r_req_value <= in_value_ext[VALUE_WIDTH-1:0];
        end
    end

    // Sequencer, entry count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                ST_CMP: begin
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_count      <= n_count;
                    r_out_valid  <= 1'b1;
                    r_out_status <= n_status;
                    r_out_hit    <= hit;
                    r_out_old    <= hit ? old_value_ext[OUT_VAL_W-1:0] : '0;
                    r_out_pos    <= hit ? pos_ext[OUT_POS_W-1:0] : '0;
                    r_out_cnt    <= cnt_ext[OUT_CNT_W-1:0];
                    r_state      <= accept ? ST_CMP : ST_IDLE;
                end
                default: begin
                    if (accept) begin
                        r_state <= ST_CMP;
                    end
                end
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_hit       = r_out_hit;
    assign o_old_value = r_out_old;
    assign o_position  = r_out_pos;
    assign o_entries   = r_out_cnt;

`ifndef SYNTHESIS
    // Entry count never passes the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Keys are unique, so the update cycle sees at most one match
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> $onehot0(cell_eq))
        else $error("more than one matching cell");

    // A result only follows an update cycle
    a_result_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($past(r_state) == ST_UPD))
        else $error("result without update cycle");

    // Entry count changes only in an update cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_UPD) |=> $stable(r_count))
        else $error("entry count changed outside update");
`endif

endmodule

/* rtl/core/sktab_cell.sv */
// One slot of the sorted table: key, value and the compare flags for the current item.
`timescale 1ns / 1ps

module sktab_cell #(
    parameter int VALUE_WIDTH = sktab_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  sktab_pkg::t_cell_ctl                i_ctl,
    input  logic                                i_occupied,
    input  logic signed [sktab_pkg::KEY_W-1:0]  i_req_key,
    input  logic [VALUE_WIDTH-1:0]              i_req_value,
    input  logic signed [sktab_pkg::KEY_W-1:0]  i_left_key,
    input  logic [VALUE_WIDTH-1:0]              i_left_value,
    input  logic                                i_left_lt,
    input  logic signed [sktab_pkg::KEY_W-1:0]  i_right_key,
    input  logic [VALUE_WIDTH-1:0]              i_right_value,
    output logic signed [sktab_pkg::KEY_W-1:0]  o_key,
    output logic [VALUE_WIDTH-1:0]              o_value,
    output logic                                o_lt,
    output logic                                o_eq
);
    import sktab_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;
    logic [VALUE_WIDTH-1:0]  r_value;
    logic [VALUE_WIDTH-1:0]  n_value;
    logic                    r_lt;
    logic                    r_eq;

    // Next contents: shift in from a neighbor, take the new entry, overwrite the value, or hold
    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        if (i_ctl.ins) begin
            if (!i_left_lt) begin
                // left neighbor sorts after the new key: everything moves right
                n_key   = i_left_key;
                n_value = i_left_value;
            end else if (!r_lt) begin
                // insertion point: first slot whose key is not below the new key
                n_key   = i_req_key;
                n_value = i_req_value;
            end
        end else if (i_ctl.del) begin
            if (!r_lt) begin
                n_key   = i_right_key;
                n_value = i_right_value;
            end
        end else if (i_ctl.ovr && r_eq) begin
            n_value = i_req_value;
        end
    end

    // Storage and compare flags (payload, no reset)
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
        if (i_ctl.cmp) begin
            r_lt <= i_occupied && (r_key < i_req_key);
            r_eq <= i_occupied && (r_key == i_req_key);
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

/* test/tb_sorted_key_value_table_core.sv */
// Testbench for the sorted key/value table core: requests checked against a local table.
`timescale 1ns / 1ps

module tb_sorted_key_value_table_core;
    import sktab_pkg::*;

    localparam int TBL_CAP     = CAPACITY_DEF;
    localparam int POOL_N      = 80;
    localparam int LIMIT_CYCLES = 100000;
    localparam int IDLE_PCT    = 14;

    // Unused kind code, handled as a lookup
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic [KIND_W-1:0]        kind;
        logic signed [KEY_W-1:0]  key;
        logic [IN_VAL_W-1:0]      value;
    } t_req;

    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic                 hit;
        logic [OUT_VAL_W-1:0] old_value;
        logic [OUT_POS_W-1:0] position;
        logic [OUT_CNT_W-1:0] entries;
    } t_rsp;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [KIND_W-1:0]          i_kind = '0;
    logic signed [KEY_W-1:0]    i_key = '0;
    logic [IN_VAL_W-1:0]        i_value = '0;
    logic                       o_valid;
    logic [STATUS_W-1:0]        o_status;
    logic                       o_hit;
    logic [OUT_VAL_W-1:0]       o_old_value;
    logic [OUT_POS_W-1:0]       o_position;
    logic [OUT_CNT_W-1:0]       o_entries;

    sorted_key_value_table_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_hit       (o_hit),
        .o_old_value (o_old_value),
        .o_position  (o_position),
        .o_entries   (o_entries)
    );

    always #10 i_clk = ~i_clk;

    // Local copy of the table, kept sorted by signed key
    logic signed [KEY_W-1:0]   tbl_key [TBL_CAP];
    logic [IN_VAL_W-1:0]       tbl_val [TBL_CAP];
    int                        tbl_count = 0;

    t_req  request_q[$];
    t_rsp  pending_results[$];
    t_req  on_ports;
    logic signed [KEY_W-1:0] key_pool [POOL_N];

    bit    steady = 1'b0;
    int    errors = 0;
    int    cycle_cnt = 0;
    int    n_sent = 0;
    int    n_hit = 0;
    int    n_miss = 0;
    int    n_full = 0;
    int    peak_count = 0;

    // Search, then apply the request to the local table; returns the result it owes
    function automatic t_rsp apply_table_request(input t_req r);
        t_rsp res;
        int lo, hi, mid, pos, i;
        bit found;
        lo = 0;
        hi = tbl_count;
        found = 1'b0;
        pos = 0;
        while (lo < hi && !found) begin
            mid = lo + (hi - lo) / 2;
            if (tbl_key[mid] < r.key) lo = mid + 1;
            else if (tbl_key[mid] > r.key) hi = mid;
            else begin
                found = 1'b1;
                pos = mid;
            end
        end
        if (!found) pos = lo;

        res.status    = STATUS_DONE;
        res.hit       = found;
        res.old_value = found ? tbl_val[pos] : '0;
        res.position  = found ? pos[OUT_POS_W-1:0] : '0;

        case (r.kind)
            KIND_INSERT: begin
                if (found) begin
                    tbl_val[pos] = r.value;
                end else if (tbl_count >= TBL_CAP) begin
                    res.status = STATUS_FULL;
                end else begin
                    for (i = tbl_count; i > pos; i--) begin
                        tbl_key[i] = tbl_key[i-1];
                        tbl_val[i] = tbl_val[i-1];
                    end
                    tbl_key[pos] = r.key;
                    tbl_val[pos] = r.value;
                    tbl_count++;
                end
            end
            KIND_DELETE: begin
                if (found) begin
                    for (i = pos; i + 1 < tbl_count; i++) begin
                        tbl_key[i] = tbl_key[i+1];
                        tbl_val[i] = tbl_val[i+1];
                    end
                    tbl_count--;
                end else begin
                    res.status = STATUS_MISS;
                end
            end
            default: begin
                if (!found) res.status = STATUS_MISS;
            end
        endcase

        res.entries = tbl_count[OUT_CNT_W-1:0];
        if (found) n_hit++;
        if (res.status == STATUS_MISS) n_miss++;
        if (res.status == STATUS_FULL) n_full++;
        if (tbl_count > peak_count) peak_count = tbl_count;
        return res;
    endfunction

    // Driver: holds start until the item is taken, then maybe idles
    always @(posedge i_clk) begin
        bit took;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            took = start && (busy === 1'b0);
            if (took) begin
                pending_results.push_back(apply_table_request(on_ports));
                n_sent++;
            end
            if (took || !start) begin
                if (request_q.size() > 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    on_ports = request_q.pop_front();
                    start   <= 1'b1;
                    i_kind  <= on_ports.kind;
                    i_key   <= on_ports.key;
                    i_value <= on_ports.value;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Monitor: every strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no item outstanding, expected none, got status %h",
                         $time, o_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("status",    32'(want.status),   32'(o_status));
                check_field("hit",       32'(want.hit),      32'(o_hit));
                check_field("old_value", want.old_value,     o_old_value);
                check_field("position",  32'(want.position), 32'(o_position));
                check_field("entries",   32'(want.entries),  32'(o_entries));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic add_item(input logic [KIND_W-1:0] kind, input logic signed [KEY_W-1:0] key,
                            input logic [IN_VAL_W-1:0] value);
        t_req r;
        r.kind  = kind;
        r.key   = key;
        r.value = value;
        request_q.push_back(r);
    endtask

    // Random items; inserts use pooled keys so the table can fill and drain again
    task automatic queue_random(input int n, input int ins_pct, input int del_pct);
        t_req r;
        int roll;
        repeat (n) begin
            roll = $urandom_range(99);
            if (roll < 4) r.kind = KIND_SPARE;
            else if (roll < 4 + ins_pct) r.kind = KIND_INSERT;
            else if (roll < 4 + ins_pct + del_pct) r.kind = KIND_DELETE;
            else r.kind = KIND_LOOKUP;
            if (r.kind != KIND_INSERT && $urandom_range(9) == 0) r.key = $urandom;
            else r.key = key_pool[$urandom_range(POOL_N - 1)];
            case ($urandom_range(9))
                0: r.value = '0;
                1: r.value = '1;
                default: r.value = $urandom;
            endcase
            request_q.push_back(r);
        end
    endtask

    // Waits until every queued item is sent and every outstanding result is back
    task automatic wait_drained();
        while (request_q.size() != 0 || start || pending_results.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        key_pool[4] = 32'sd1;
        for (int i = 5; i < POOL_N; i++) key_pool[i] = $urandom;

        // Directed: empty table, extremes, overwrite, kind three, gaps closed
        add_item(KIND_LOOKUP, 32'sd0, 32'h0);
        add_item(KIND_DELETE, 32'sd5, 32'h0);
        add_item(KIND_SPARE,  -32'sd1, 32'hFFFF_FFFF);
        add_item(KIND_INSERT, KEY_MAX, 32'hFFFF_FFFF);
        add_item(KIND_INSERT, KEY_MIN, 32'h0);
        add_item(KIND_INSERT, 32'sd0, 32'h1234_5678);
        add_item(KIND_INSERT, -32'sd1, 32'hA5A5_A5A5);
        add_item(KIND_INSERT, 32'sd1, 32'h5A5A_5A5A);
        add_item(KIND_LOOKUP, KEY_MIN, 32'h0);
        add_item(KIND_LOOKUP, KEY_MAX, 32'h0);
        add_item(KIND_SPARE,  32'sd0, 32'h0);
        add_item(KIND_INSERT, 32'sd0, 32'hFFFF_FFFF);
        add_item(KIND_LOOKUP, 32'sd7, 32'h0);
        add_item(KIND_DELETE, -32'sd1, 32'h0);
        add_item(KIND_LOOKUP, 32'sd1, 32'h0);
        add_item(KIND_DELETE, KEY_MIN, 32'h0);
        add_item(KIND_DELETE, KEY_MAX, 32'h0);
        add_item(KIND_DELETE, 32'sd2, 32'h0);
        add_item(KIND_INSERT, -32'sd1, 32'h0);
        add_item(KIND_LOOKUP, -32'sd1, 32'h0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait_drained();
        queue_random(400, 60, 15);      // fill up, hit the full case
        wait_drained();
        steady = 1'b1;                  // back-to-back stretch
        queue_random(400, 30, 30);
        wait_drained();
        steady = 1'b0;
        queue_random(400, 10, 65);      // drain the table
        wait_drained();
        queue_random(300, 30, 30);
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Ran %0d requests: %0d hits, %0d not found, %0d rejected as full.",
                 n_sent, n_hit, n_miss, n_full);
        $display("Table held up to %0d of %0d entries; %0d checks failed.",
                 peak_count, TBL_CAP, errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
